[design/rdr_pkg.sv]
// Shared types and constants for the radix digit reverser.
package rdr_pkg;

  localparam int unsigned DataW         = 64;
  localparam int unsigned RadixW        = 9;
  localparam int unsigned ValueWidthDef = 64;

  localparam logic [RadixW-1:0] RadixMin = RadixW'(2);
  localparam logic [RadixW-1:0] RadixMax = RadixW'(256);

  typedef struct packed {
    logic [DataW-1:0]  value;
    logic [RadixW-1:0] radix;
  } in_t;

  typedef struct packed {
    logic [DataW-1:0] reversed;
    logic             overflow;
  } out_t;

endpackage

[design/radix_digit_reverser_unit.sv]
// Radix digit reverser: serial divider and multiply-accumulate under one sequencer.
//
//  Channel | Ports                 | Handshake
//  --------+-----------------------+--------------------------------------------
//  in      | start_i, busy_o, in_i | item taken when start_i high and busy_o low
//  out     | valid_o, out_o        | one-cycle strobe, receiver cannot stall
//
// Each digit is found by VALUE_WIDTH steps of the bit-serial divider by the
// radix, then one multiply-accumulate step; the unit takes no new item until
// the last digit of the current one is in. A zero value returns in the cycle
// after it is taken. busy_o is high while an item is in work. rst_ni clears
// the sequencer and the strobe asynchronously.
module radix_digit_reverser_unit #(
  parameter int unsigned VALUE_WIDTH = rdr_pkg::ValueWidthDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  output logic         busy_o,
  input  rdr_pkg::in_t in_i,
  output logic         valid_o,
  output rdr_pkg::out_t out_o
);

  import rdr_pkg::*;

  localparam int unsigned CntW  = $clog2(VALUE_WIDTH);
  localparam int unsigned ProdW = VALUE_WIDTH + RadixW;

  typedef enum logic [1:0] {
    StIdle,
    StDiv,
    StMac
  } state_e;

  state_e                   state_q;
  logic [VALUE_WIDTH-1:0]   v_q;
  logic [VALUE_WIDTH-1:0]   acc_q;
  logic [RadixW-1:0]        b_q;
  logic [7:0]               rem_q;
  logic [CntW-1:0]          cnt_q;
  logic                     ovf_q;
  logic                     valid_q;
  out_t                     out_q;

  logic [VALUE_WIDTH-1:0]   v_in;
  logic [RadixW-1:0]        b_in;
  logic [RadixW-1:0]        rem_sh;
  logic                     q_bit;
  logic [RadixW-1:0]        rem_sub;
  logic [ProdW-1:0]         mac;
  logic                     mac_ovf;

  always_comb begin
    v_in = in_i.value[VALUE_WIDTH-1:0];
    if (in_i.radix < RadixMin) begin
      b_in = RadixMin;
    end else if (in_i.radix > RadixMax) begin
      b_in = RadixMax;
    end else begin
      b_in = in_i.radix;
    end
  end

  always_comb begin
    rem_sh  = {rem_q, v_q[VALUE_WIDTH-1]};
    q_bit   = (rem_sh >= b_q);
    rem_sub = q_bit ? (rem_sh - b_q) : rem_sh;
    mac     = ProdW'(acc_q) * ProdW'(b_q) + ProdW'(rem_q);
    mac_ovf = |mac[ProdW-1:VALUE_WIDTH];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      valid_q <= 1'b0;
      v_q     <= '0;
      acc_q   <= '0;
      b_q     <= RadixMin;
      rem_q   <= '0;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
      out_q   <= '0;
    end else begin
      valid_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (start_i) begin
            v_q   <= v_in;
            b_q   <= b_in;
            acc_q <= '0;
            ovf_q <= 1'b0;
            rem_q <= '0;
            cnt_q <= CntW'(VALUE_WIDTH - 1);
            if (v_in == '0) begin
              valid_q        <= 1'b1;
              out_q.reversed <= '0;
              out_q.overflow <= 1'b0;
            end else begin
              state_q <= StDiv;
            end
          end
        end
        StDiv: begin
          v_q   <= {v_q[VALUE_WIDTH-2:0], q_bit};
          rem_q <= rem_sub[7:0];
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == '0) begin
            state_q <= StMac;
          end
        end
        StMac: begin
          acc_q <= mac[VALUE_WIDTH-1:0];
          ovf_q <= ovf_q | mac_ovf;
          rem_q <= '0;
          cnt_q <= CntW'(VALUE_WIDTH - 1);
          if (v_q == '0) begin
            valid_q        <= 1'b1;
            out_q.reversed <= DataW'(mac[VALUE_WIDTH-1:0]);
            out_q.overflow <= ovf_q | mac_ovf;
            state_q        <= StIdle;
          end else begin
            state_q <= StDiv;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign busy_o  = (state_q != StIdle);
  assign valid_o = valid_q;
  assign out_o   = out_q;

endmodule
